FILE: sv/signed_int_to_decimal_ascii_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal text converter.
// The macros expect clk and arst_n in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication.
`define SITOA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SITOA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/sitoa_pkg.sv
// ---------------------------------------------------------------------------
// sitoa_pkg
// Shared constants, types and the double-dabble step for the converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sitoa_pkg;

	localparam int VALUE_W       = 32;
	localparam int DIGITS        = 10;
	localparam int BCD_W         = 4 * DIGITS;
	localparam int DABBLE_STEPS  = 4;
	localparam int DABBLE_STAGES = VALUE_W / DABBLE_STEPS;
	localparam int IDX_W         = $clog2(DIGITS);
	localparam int CHAR_W        = 8;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic               neg;
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
	} dabble_t;

	typedef logic [DIGITS-1:0][3:0] digits_t;

	function automatic dabble_t dabble_step(input dabble_t cur);
		dabble_t    nxt;
		logic [3:0] dig;
		nxt = cur;
		for (int d = 0; d < DIGITS; d++) begin
			dig = cur.bcd[4*d +: 4];
			if (dig >= 4'd5) begin
				nxt.bcd[4*d +: 4] = dig + 4'd3;
			end
		end
		nxt.bcd = {nxt.bcd[BCD_W-2:0], nxt.bin[VALUE_W-1]};
		nxt.bin = {nxt.bin[VALUE_W-2:0], 1'b0};
		return nxt;
	endfunction

endpackage

`default_nettype wire

FILE: sv/sitoa_mag.sv
// ---------------------------------------------------------------------------
// sitoa_mag
// First stage: splits the value into sign and unsigned magnitude.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitoa_mag (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [sitoa_pkg::VALUE_W-1:0] in_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output sitoa_pkg::dabble_t                 out_item
);

	logic               valid_s1;
	sitoa_pkg::dabble_t item_s1;
	sitoa_pkg::dabble_t item_d;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		item_d.neg = in_value[sitoa_pkg::VALUE_W-1];
		item_d.bcd = '0;
		item_d.bin = item_d.neg ? ('0 - in_value) : in_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

`default_nettype wire

FILE: sv/sitoa_dabble.sv
// ---------------------------------------------------------------------------
// sitoa_dabble
// One pipeline stage of the binary to BCD conversion, DABBLE_STEPS shift steps deep.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitoa_dabble (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sitoa_pkg::dabble_t in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output sitoa_pkg::dabble_t      out_item
);

	logic               valid_s1;
	sitoa_pkg::dabble_t item_s1;
	sitoa_pkg::dabble_t item_d;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		item_d = in_item;
		for (int s = 0; s < sitoa_pkg::DABBLE_STEPS; s++) begin
			item_d = sitoa_pkg::dabble_step(item_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

`default_nettype wire

FILE: sv/sitoa_emit.sv
// ---------------------------------------------------------------------------
// sitoa_emit
// Serializer that sends the minus sign, if any, and the significant digits, one per cycle while the output is ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sitoa_emit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire sitoa_pkg::dabble_t            in_item,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [sitoa_pkg::CHAR_W-1:0]       out_char,
	output logic                               out_last
);

	logic                          busy_q;
	logic                          sign_q;
	logic [sitoa_pkg::IDX_W-1:0]   idx_q;
	sitoa_pkg::digits_t            digits_q;
	sitoa_pkg::digits_t            in_digits;
	logic [sitoa_pkg::IDX_W-1:0]   msd;
	logic                          load;

	assign in_digits = in_item.bcd;

	always_comb begin
		msd = '0;
		for (int i = 0; i < sitoa_pkg::DIGITS; i++) begin
			if (in_digits[i] != 4'd0) begin
				msd = sitoa_pkg::IDX_W'(i);
			end
		end
	end

	assign out_valid = busy_q;
	assign out_last  = !sign_q && (idx_q == '0);
	assign out_char  = sign_q ? sitoa_pkg::CHAR_MINUS
	                          : (sitoa_pkg::CHAR_ZERO | {4'd0, digits_q[idx_q]});
	assign in_ready  = !busy_q || (out_ready && out_last);
	assign load      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			sign_q <= in_item.neg;
			idx_q  <= msd;
		end else if (busy_q && out_ready) begin
			if (out_last) begin
				busy_q <= 1'b0;
			end else if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= in_digits;
		end
	end

endmodule

`default_nettype wire

FILE: sv/signed_int_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text.
// ---------------------------------------------------------------------------
// Channel  Dir  Contents
// s_axis   in   tdata[31:0] value (two's complement)
// m_axis   out  tdata[7:0] text_char, tlast last_char
//
// Each request yields 1 to 11 characters, one per cycle while m_axis is ready;
// the serializer takes the next request as its last character is accepted.
// A request passes a magnitude stage and eight BCD shift stages before it
// reaches the serializer; requests may enter every cycle until it backs up.
// Reset is asynchronous and clears only the valid bits and serializer state.
// Stalls on the output hold each stage; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] value
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] text_char
	output logic             m_axis_tlast
);

	localparam int NSTG = sitoa_pkg::DABBLE_STAGES;

	logic               stg_valid [NSTG+1];
	logic               stg_ready [NSTG+1];
	sitoa_pkg::dabble_t stg_item  [NSTG+1];

	sitoa_mag u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_value  (s_axis_tdata),
		.out_valid (stg_valid[0]),
		.out_ready (stg_ready[0]),
		.out_item  (stg_item[0])
	);

	for (genvar g = 0; g < NSTG; g++) begin : g_dabble
		sitoa_dabble u_dabble (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[g]),
			.in_ready  (stg_ready[g]),
			.in_item   (stg_item[g]),
			.out_valid (stg_valid[g+1]),
			.out_ready (stg_ready[g+1]),
			.out_item  (stg_item[g+1])
		);
	end

	sitoa_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_valid[NSTG]),
		.in_ready  (stg_ready[NSTG]),
		.in_item   (stg_item[NSTG]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	`SITOA_ASSERT_NOW(a_minus_not_last,
		m_axis_tvalid && (m_axis_tdata == sitoa_pkg::CHAR_MINUS), !m_axis_tlast,
		"A minus sign was marked as the last character.")

	`SITOA_ASSERT_NOW(a_char_legal, m_axis_tvalid,
		(m_axis_tdata == sitoa_pkg::CHAR_MINUS) ||
		((m_axis_tdata >= 8'h30) && (m_axis_tdata <= 8'h39)),
		"Output character is neither a digit nor a minus sign.")

	`SITOA_ASSERT_NEXT(a_text_continues,
		m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid,
		"Text of a number stopped before its last character.")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench for signed_int_to_decimal_ascii. Signed 32-bit values are sent as
// requests on the input stream. A local predictor turns each accepted
// request into its expected decimal characters. Every character on the
// output stream is compared against the oldest expected one, in both the
// character and the last flag. Both sides idle at random except in the
// closing back-to-back part.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last_char;
	} text_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // [31:0] value
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;  // [7:0] text_char
	logic        m_axis_tlast;

	text_item_t  pending_text[$];
	int          mismatch_count = 0;
	bit          source_gaps = 1'b1;
	bit          sink_stalls = 1'b1;

	signed_int_to_decimal_ascii dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void predict_text(input logic [31:0] value);
		logic [31:0] magnitude;
		logic [7:0]  digit_chars[10];
		int          n_digits;
		magnitude = value[31] ? (~value + 32'd1) : value;
		n_digits = 0;
		do begin
			digit_chars[n_digits] = sitoa_pkg::CHAR_ZERO + 8'(magnitude % 32'd10);
			n_digits++;
			magnitude = magnitude / 32'd10;
		end while (magnitude != 32'd0);
		if (value[31]) begin
			pending_text.push_back('{text_char: sitoa_pkg::CHAR_MINUS, last_char: 1'b0});
		end
		for (int k = n_digits - 1; k >= 0; k--) begin
			pending_text.push_back('{text_char: digit_chars[k], last_char: (k == 0)});
		end
	endfunction

	// Called at a rising edge; returns at the edge where the request is taken, or after a random gap with valid low.
	task automatic send_value(input logic [31:0] value);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		predict_text(value);
		if (source_gaps && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic test_extremes();
		logic [31:0] corner_values[$];
		corner_values = {32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
			32'd100, -32'sd999, 32'd1000, 32'd99999, -32'sd100000, 32'd1234567,
			-32'sd10000000, 32'd99999999, -32'sd100000000, 32'd999999999,
			32'd1000000000, -32'sd1999999999, 32'h7FFF_FFFF, 32'h8000_0001,
			32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
		foreach (corner_values[i]) begin
			send_value(corner_values[i]);
		end
	endtask

	task automatic test_random_bits(input int count);
		repeat (count) begin
			send_value($urandom);
		end
	endtask

	// Uniform bits give mostly ten-digit numbers, so pick the length first.
	task automatic test_digit_lengths(input int count);
		longint lo;
		longint hi;
		longint pick;
		int     n_digits;
		repeat (count) begin
			n_digits = $urandom_range(1, 10);
			lo = (n_digits == 1) ? 0 : 64'(10) ** (n_digits - 1);
			hi = 64'(10) ** n_digits - 1;
			if (hi > 64'h7FFF_FFFF) begin
				hi = 64'h7FFF_FFFF;
			end
			pick = lo + longint'($urandom) % (hi - lo + 1);
			if ($urandom_range(0, 1) == 1) begin
				pick = -pick;
			end
			if ($urandom_range(0, 40) == 0) begin
				pick = -64'h8000_0000;
			end
			send_value(pick[31:0]);
		end
	endtask

	task automatic test_back_to_back(input int count);
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		test_digit_lengths(count / 2);
		test_random_bits(count - count / 2);
	endtask

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		arst_n        = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		forever begin
			if (sink_stalls && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		text_item_t expected;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_text.size() == 0) begin
				$display("%0t: unexpected character, expected none, actual char 0x%02h last %0b",
					$time, m_axis_tdata, m_axis_tlast);
				mismatch_count++;
			end else begin
				expected = pending_text.pop_front();
				if (m_axis_tdata !== expected.text_char) begin
					$display("%0t: text_char mismatch, expected 0x%02h, actual 0x%02h",
						$time, expected.text_char, m_axis_tdata);
					mismatch_count++;
				end
				if (m_axis_tlast !== expected.last_char) begin
					$display("%0t: last_char mismatch, expected %0b, actual %0b",
						$time, expected.last_char, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		test_extremes();
		test_random_bits(200);
		test_digit_lengths(135);
		test_back_to_back(60);
		s_axis_tvalid <= 1'b0;
		while (pending_text.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
